// ===== hw/rtl/plel_pkg.sv =====
// Package for the positional list engine: opcodes, status codes, field widths
// and the control word passed from the decoder to the row of cells.
// Depends on nothing.
package plel_pkg;

  // Widths of the request and response fields.
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned POSITION_W = 7;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;

  // Default number of words the list can hold.
  localparam int unsigned DEF_CAPACITY = 64;

  // Request opcodes. The eighth code is unused and answers OK with no effect.
  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Decoded action of one request, handed from the decoder to the cells.
  typedef struct packed {
    logic    ins;     // open a gap at the target index and store the word
    logic    rem;     // take the word at the target index and close the gap
    logic    rd;      // read the word at the target index
    status_t status;
  } ctl_t;

endpackage

// ===== hw/rtl/plel_in_if.sv =====
// Request channel of the positional list engine: valid/ready and the payload.
// Depends on plel_pkg.
interface plel_in_if;
  logic                                valid;
  logic                                ready;
  logic [plel_pkg::OPCODE_W-1:0]       opcode;
  logic [plel_pkg::POSITION_W-1:0]     position;
  logic signed [plel_pkg::WORD_W-1:0]  value_in;

  modport source (output valid, output opcode, output position, output value_in,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value_in,
                  output ready);
endinterface

// ===== hw/rtl/plel_out_if.sv =====
// Response channel of the positional list engine: valid/ready and the payload.
// Depends on plel_pkg.
interface plel_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plel_pkg::WORD_W-1:0]  value_out;
  logic [plel_pkg::STATUS_W-1:0]       status;
  logic [plel_pkg::COUNT_W-1:0]        count_out;
  logic                                empty_flag;

  modport source (output valid, output value_out, output status, output count_out,
                  output empty_flag, input ready);
  modport sink   (input valid, input value_out, input status, input count_out,
                  input empty_flag, output ready);
endinterface

// ===== hw/rtl/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of up to CAPACITY words held in a
// row of cells; every cell at or above the target index shifts in the same
// cycle on insert or removal. The response is registered and is valid in the
// cycle after the request is taken; one request is accepted every cycle while
// the response register is free or being taken, as the whole row shifts at once.
// Synchronous reset empties the list; cell contents are not cleared.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = plel_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  plel_in_if.sink   req,
  plel_out_if.source rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned OW = (CW > plel_pkg::COUNT_W) ? CW : plel_pkg::COUNT_W;

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  plel_pkg::ctl_t                 ctl;
  logic [AW-1:0]                  at;
  logic                           fire;
  logic [plel_pkg::WORD_W-1:0]    data     [CAPACITY];
  logic [plel_pkg::WORD_W-1:0]    hit_data [CAPACITY];
  logic [plel_pkg::WORD_W-1:0]    sel_word;
  logic [OW-1:0]                  count_ext;

  // A request is taken whenever the response register is empty or draining.
  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  // Decode the request against the current count.
  plel_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .opcode     (req.opcode),
    .position   (req.position),
    .count      (count),
    .ctl        (ctl),
    .at         (at),
    .count_next (count_next)
  );

  // Row of cells; each neighbour feeds the next on every shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [plel_pkg::WORD_W-1:0] left_w;
    logic [plel_pkg::WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = req.value_in;
    end else begin : g_inner_l
      assign left_w = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = data[i];
    end else begin : g_inner_r
      assign right_w = data[i+1];
    end
    plel_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .en       (fire),
      .ctl      (ctl),
      .at       (at),
      .word     (req.value_in),
      .left     (left_w),
      .right    (right_w),
      .data     (data[i]),
      .hit_data (hit_data[i])
    );
  end

  // Only the target cell offers its word and all others offer zero, so an OR gathers it.
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | hit_data[i];
    end
  end

  assign count_ext = OW'(count_next);

  // Word count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.value_out  <= (ctl.rem || ctl.rd) ? sel_word : '0;
      rsp.status     <= ctl.status;
      rsp.count_out  <= count_ext[plel_pkg::COUNT_W-1:0];
      rsp.empty_flag <= (count_next == '0);
    end
  end

endmodule

// ===== hw/rtl/plel_cell.sv =====
// One cell of the list row: holds a single word and takes a new one from its
// left or right neighbour, or from the request, as the decoded action says.
// Depends on plel_pkg.
module plel_cell #(
  parameter int unsigned AW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  plel_pkg::ctl_t              ctl,
  input  logic [AW-1:0]               at,
  input  logic [plel_pkg::WORD_W-1:0] word,
  input  logic [plel_pkg::WORD_W-1:0] left,
  input  logic [plel_pkg::WORD_W-1:0] right,
  output logic [plel_pkg::WORD_W-1:0] data,
  output logic [plel_pkg::WORD_W-1:0] hit_data
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic hit;
  logic above;

  // Position of this cell relative to the target index.
  assign hit   = (at == MY_IDX);
  assign above = (MY_IDX > at);

  // The word is offered to the read-out only when this cell is the target.
  assign hit_data = hit ? data : '0;

  // Shift right on insert, shift left on removal, otherwise hold.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.ins) begin
        if (above) begin
          data <= left;
        end else if (hit) begin
          data <= word;
        end
      end else if (ctl.rem) begin
        if (above || hit) begin
          data <= right;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/plel_ctrl.sv =====
// Request decoder of the positional list engine: works out the target index,
// the fault checks and the new word count from the opcode and current count.
// Depends on plel_pkg.
module plel_ctrl #(
  parameter int unsigned CAPACITY = plel_pkg::DEF_CAPACITY,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic [plel_pkg::OPCODE_W-1:0]   opcode,
  input  logic [plel_pkg::POSITION_W-1:0] position,
  input  logic [CW-1:0]                   count,
  output plel_pkg::ctl_t                  ctl,
  output logic [AW-1:0]                   at,
  output logic [CW-1:0]                   count_next
);

  localparam int unsigned MW = (CW > plel_pkg::POSITION_W) ? CW : plel_pkg::POSITION_W;
  localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

  logic [MW-1:0] cnt_m;
  logic [MW-1:0] pos_m;
  logic [MW-1:0] at_m;

  assign cnt_m = MW'(count);
  assign pos_m = MW'(position);
  assign at    = at_m[AW-1:0];

  // Decode the opcode into one action and a status.
  always_comb begin
    ctl        = '{ins: 1'b0, rem: 1'b0, rd: 1'b0, status: plel_pkg::ST_OK};
    at_m       = '0;
    count_next = count;
    case (plel_pkg::op_t'(opcode))
      plel_pkg::OP_INS_FRONT, plel_pkg::OP_INS_BACK, plel_pkg::OP_INS_AT: begin
        if (plel_pkg::op_t'(opcode) == plel_pkg::OP_INS_BACK) begin
          at_m = cnt_m;
        end else if (plel_pkg::op_t'(opcode) == plel_pkg::OP_INS_AT) begin
          at_m = pos_m;
        end
        if (at_m > cnt_m) begin
          ctl.status = plel_pkg::ST_RANGE;
        end else if (cnt_m >= CAP_M) begin
          ctl.status = plel_pkg::ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      plel_pkg::OP_REM_FRONT, plel_pkg::OP_REM_BACK, plel_pkg::OP_REM_AT: begin
        if (plel_pkg::op_t'(opcode) == plel_pkg::OP_REM_BACK) begin
          at_m = cnt_m - MW'(1);
        end else if (plel_pkg::op_t'(opcode) == plel_pkg::OP_REM_AT) begin
          at_m = pos_m;
        end
        if (cnt_m == '0) begin
          ctl.status = plel_pkg::ST_EMPTY;
        end else if (at_m >= cnt_m) begin
          ctl.status = plel_pkg::ST_RANGE;
        end else begin
          ctl.rem    = 1'b1;
          count_next = count - CW'(1);
        end
      end
      plel_pkg::OP_READ_AT: begin
        at_m = pos_m;
        if (at_m >= cnt_m) begin
          ctl.status = plel_pkg::ST_RANGE;
        end else begin
          ctl.rd = 1'b1;
        end
      end
      default: begin
        ctl.status = plel_pkg::ST_OK;
      end
    endcase
  end

endmodule
